// ===== sv/http_chunked_decoder_assert.svh =====
// Assertion macros for the chunked body decoder.
// Included by the top level; depends on nothing else.
`ifndef HTTP_CHUNKED_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HCD_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("http_chunked_decoder: assertion failed");

// Next-cycle implication, disabled during reset
`define HCD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("http_chunked_decoder: assertion failed");

`endif

// ===== sv/hcd_pkg.sv =====
// Shared types, constants and helpers of the chunked body decoder.
// No dependencies; used by the size line parser and the top level.
package hcd_pkg;

  localparam int SIZE_BITS = 32;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_X_LO  = 8'h78;
  localparam logic [7:0] CHAR_X_UP  = 8'h58;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  typedef enum logic [3:0] {
    MODE_LEAD,
    MODE_SIGN,
    MODE_DIGITS,
    MODE_TAIL,
    MODE_DATA,
    MODE_POST_CR,
    MODE_POST_LF,
    MODE_PASS,
    MODE_STOP
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_ZERO_CHUNK    = 2'd0,
    STATUS_TRUNCATED     = 2'd1,
    STATUS_BAD_SIZE      = 2'd2,
    STATUS_NO_TERMINATOR = 2'd3
  } status_t;

  // Size line state: mode, accumulator, parse flags, pending CR
  typedef struct packed {
    mode_t                mode;
    logic [SIZE_BITS-1:0] acc;
    logic                 digit;
    logic                 neg;
    logic                 prefix;
    logic                 over;
    logic                 cr;
  } line_state_t;

  localparam line_state_t LINE_RESET = '{
    mode:   MODE_LEAD,
    acc:    '0,
    digit:  1'b0,
    neg:    1'b0,
    prefix: 1'b0,
    over:   1'b0,
    cr:     1'b0
  };

  // Whitespace as the C library sees it: space, tab through CR
  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== sv/hcd_if.sv =====
// Handshake channels of the chunked body decoder: raw body in, payload out.
// No dependencies.
interface hcd_body_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       end_of_body;

  modport source(output valid, body_byte, end_of_body, input ready);
  modport sink(input valid, body_byte, end_of_body, output ready);
endinterface

interface hcd_payload_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic       body_done;
  logic [1:0] end_status;

  modport source(output valid, payload_byte, payload_valid, body_done, end_status,
                 input ready);
  modport sink(input valid, payload_byte, payload_valid, body_done, end_status,
               output ready);
endinterface

// ===== sv/http_chunked_decoder.sv =====
// Channel   Role  Payload
// body      sink  body_byte[7:0], end_of_body
// payload   src   payload_byte[7:0], payload_valid, body_done, end_status[1:0]
//
// One byte per cycle while body.ready is high: each accepted byte updates the parse
// state in the same cycle and its result, if any, lands in the output register.
// The output register is the only buffer; body.ready drops only while a result
// waits there and payload.ready is low.
// Synchronous reset clears the parse state and the output register.
// The byte marked end_of_body returns all parse state to its reset value.
//
// Depends on hcd_pkg, hcd_if, hcd_size_line and http_chunked_decoder_assert.svh.
`include "http_chunked_decoder_assert.svh"

module http_chunked_decoder (
  input logic           clk,
  input logic           rst,
  hcd_body_if.sink      body,
  hcd_payload_if.source payload
);

  hcd_pkg::line_state_t           line;
  hcd_pkg::line_state_t           line_step;
  hcd_pkg::line_state_t           parse_in;
  hcd_pkg::line_state_t           parse_out;
  logic                           parse_end;
  logic [hcd_pkg::SIZE_BITS-1:0]  bytes_left;
  logic [hcd_pkg::SIZE_BITS-1:0]  bytes_left_step;
  hcd_pkg::status_t               stop_cause;
  hcd_pkg::status_t               stop_cause_step;

  logic                           accept;
  logic                           res_valid;
  logic                           res_payload_valid;
  logic [7:0]                     res_byte;
  hcd_pkg::status_t               res_status;

  logic                           out_valid;
  logic [7:0]                     out_byte;
  logic                           out_payload_valid;
  logic                           out_done;
  hcd_pkg::status_t               out_status;

  // Accept while the output register is empty or draining
  assign body.ready = !out_valid || payload.ready;
  assign accept     = body.valid && body.ready;

  // After a chunk's data the next size line starts clean, even without its CR LF
  assign parse_in = (line.mode == hcd_pkg::MODE_POST_CR || line.mode == hcd_pkg::MODE_POST_LF)
                  ? hcd_pkg::LINE_RESET : line;

  hcd_size_line u_size_line (
    .cur      (parse_in),
    .ch       (body.body_byte),
    .nxt      (parse_out),
    .line_end (parse_end)
  );

  // Next state for one byte, before the end-of-body reset
  always_comb begin
    logic use_parser;
    use_parser      = 1'b0;
    line_step       = line;
    bytes_left_step = bytes_left;
    stop_cause_step = stop_cause;
    case (line.mode)
      hcd_pkg::MODE_DATA: begin
        bytes_left_step = bytes_left - hcd_pkg::SIZE_BITS'(1);
        if (bytes_left == hcd_pkg::SIZE_BITS'(1)) begin
          line_step.mode = hcd_pkg::MODE_POST_CR;
        end
      end
      hcd_pkg::MODE_POST_CR: begin
        if (body.body_byte == hcd_pkg::CHAR_CR) begin
          line_step.mode = hcd_pkg::MODE_POST_LF;
        end else begin
          use_parser = 1'b1;
        end
      end
      hcd_pkg::MODE_POST_LF: begin
        if (body.body_byte == hcd_pkg::CHAR_LF) begin
          line_step = hcd_pkg::LINE_RESET;
        end else begin
          use_parser = 1'b1;
        end
      end
      hcd_pkg::MODE_PASS, hcd_pkg::MODE_STOP: begin
      end
      default: begin
        use_parser = 1'b1;
      end
    endcase

    // Size line bytes, and the decision at the end of the line
    if (use_parser) begin
      line_step = parse_out;
      if (parse_end) begin
        if (!parse_out.digit || parse_out.over) begin
          line_step.mode  = hcd_pkg::MODE_STOP;
          stop_cause_step = hcd_pkg::STATUS_BAD_SIZE;
        end else if (parse_out.acc == '0) begin
          line_step.mode  = hcd_pkg::MODE_STOP;
          stop_cause_step = hcd_pkg::STATUS_ZERO_CHUNK;
        end else if (parse_out.neg) begin
          line_step.mode = hcd_pkg::MODE_PASS;
        end else begin
          line_step.mode  = hcd_pkg::MODE_DATA;
          bytes_left_step = parse_out.acc;
        end
      end
    end
  end

  // Result for one byte
  always_comb begin
    res_payload_valid = (line.mode == hcd_pkg::MODE_DATA) || (line.mode == hcd_pkg::MODE_PASS);
    res_byte          = res_payload_valid ? body.body_byte : 8'd0;
    res_valid         = res_payload_valid || body.end_of_body;
    res_status        = hcd_pkg::STATUS_ZERO_CHUNK;
    if (body.end_of_body) begin
      if (line_step.mode == hcd_pkg::MODE_STOP) begin
        res_status = stop_cause_step;
      end else if (line_step.mode == hcd_pkg::MODE_DATA ||
                   line_step.mode == hcd_pkg::MODE_PASS) begin
        res_status = hcd_pkg::STATUS_TRUNCATED;
      end else begin
        res_status = hcd_pkg::STATUS_NO_TERMINATOR;
      end
    end
  end

  // Advance parse state on each accepted item; restart after the end byte
  always_ff @(posedge clk) begin
    if (rst) begin
      line       <= hcd_pkg::LINE_RESET;
      bytes_left <= '0;
      stop_cause <= hcd_pkg::STATUS_ZERO_CHUNK;
    end else if (accept) begin
      if (body.end_of_body) begin
        line       <= hcd_pkg::LINE_RESET;
        bytes_left <= '0;
        stop_cause <= hcd_pkg::STATUS_ZERO_CHUNK;
      end else begin
        line       <= line_step;
        bytes_left <= bytes_left_step;
        stop_cause <= stop_cause_step;
      end
    end
  end

  // Output register: load when an item yields a result, else drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid <= 1'b1;
    end else if (payload.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_byte          <= res_byte;
      out_payload_valid <= res_payload_valid;
      out_done          <= body.end_of_body;
      out_status        <= res_status;
    end
  end

  assign payload.valid         = out_valid;
  assign payload.payload_byte  = out_byte;
  assign payload.payload_valid = out_payload_valid;
  assign payload.body_done     = out_done;
  assign payload.end_status    = out_status;

  `HCD_ASSERT_IMPLY(a_no_overwrite, clk, rst, out_valid && !payload.ready, !body.ready)
  `HCD_ASSERT_IMPLY(a_data_nonzero, clk, rst, line.mode == hcd_pkg::MODE_DATA, bytes_left != '0)
  `HCD_ASSERT_IMPLY(a_result_nonempty, clk, rst, out_valid, out_payload_valid || out_done)
  `HCD_ASSERT_NEXT(a_end_restarts, clk, rst, accept && body.end_of_body,
                   line.mode == hcd_pkg::MODE_LEAD && bytes_left == '0)

endmodule

// ===== sv/hcd_size_line.sv =====
// Size line parser: one byte of a chunk size line, strtoul base 16 style.
// Depends on hcd_pkg.
module hcd_size_line (
  input  hcd_pkg::line_state_t cur,
  input  logic [7:0]           ch,
  output hcd_pkg::line_state_t nxt,
  output logic                 line_end
);

  logic [4:0] hex;
  logic       first_digit;
  logic       take;
  logic       zero_lead;

  assign hex = hcd_pkg::hex_digit(ch);

  always_comb begin
    nxt         = cur;
    line_end    = 1'b0;
    first_digit = 1'b0;
    take        = 1'b0;
    zero_lead   = 1'b0;
    if (cur.cr && ch == hcd_pkg::CHAR_LF) begin
      // CR LF closes the line
      line_end = 1'b1;
      nxt.cr   = 1'b0;
    end else begin
      // A stray CR acts as whitespace: it ends a sign or a digit run
      if (cur.cr) begin
        nxt.cr = 1'b0;
        if (cur.mode == hcd_pkg::MODE_SIGN || cur.mode == hcd_pkg::MODE_DIGITS) begin
          nxt.mode   = hcd_pkg::MODE_TAIL;
          nxt.prefix = 1'b0;
        end
      end
      if (ch == hcd_pkg::CHAR_CR) begin
        nxt.cr = 1'b1;
      end else begin
        case (nxt.mode)
          hcd_pkg::MODE_LEAD: begin
            if (hcd_pkg::is_space(ch)) begin
              // skip leading whitespace
            end else if (ch == hcd_pkg::CHAR_PLUS || ch == hcd_pkg::CHAR_MINUS) begin
              nxt.neg  = nxt.neg | (ch == hcd_pkg::CHAR_MINUS);
              nxt.mode = hcd_pkg::MODE_SIGN;
            end else begin
              first_digit = 1'b1;
            end
          end
          hcd_pkg::MODE_SIGN: begin
            first_digit = 1'b1;
          end
          hcd_pkg::MODE_DIGITS: begin
            if (nxt.prefix && (ch == hcd_pkg::CHAR_X_LO || ch == hcd_pkg::CHAR_X_UP)) begin
              nxt.prefix = 1'b0;
            end else begin
              nxt.prefix = 1'b0;
              if (hex[4]) begin
                take = 1'b1;
              end else begin
                nxt.mode = hcd_pkg::MODE_TAIL;
              end
            end
          end
          default: begin
          end
        endcase

        // First character after whitespace or sign
        if (first_digit) begin
          if (hex[4]) begin
            take      = 1'b1;
            zero_lead = (hex[3:0] == 4'd0);
          end else begin
            nxt.mode = hcd_pkg::MODE_TAIL;
          end
        end

        // Shift in a digit unless the size would overflow
        if (take) begin
          if (!nxt.over) begin
            if (nxt.acc[hcd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
              nxt.over = 1'b1;
            end else begin
              nxt.acc = {nxt.acc[hcd_pkg::SIZE_BITS-5:0], hex[3:0]};
            end
          end
          nxt.digit = 1'b1;
          nxt.mode  = hcd_pkg::MODE_DIGITS;
          if (zero_lead) begin
            nxt.prefix = 1'b1;
          end
        end
      end
    end
  end

endmodule
